/* src/lcfe_pkg.sv */
`timescale 1ns / 1ps
package lcfe_pkg;

   localparam int CHANNELS = 8;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LEVEL_W  = 8;
   localparam int FIELDS   = 8;

   typedef logic [LEVEL_W-1:0] level_type;

   localparam logic [1:0] OP_SET_ONE = 2'd0;
   localparam logic [1:0] OP_MASKED  = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam level_type STEP_RESET = 8'h01;

   typedef struct packed {
      logic [1:0] operation;
      logic [2:0] channel;
      level_type  step;
      logic [7:0] mask;
      level_type  value_0;
      level_type  value_1;
      level_type  value_2;
      level_type  value_3;
      level_type  value_4;
      level_type  value_5;
      level_type  value_6;
      level_type  value_7;
   } req_word_type;

   typedef struct packed {
      level_type level_0;
      level_type level_1;
      level_type level_2;
      level_type level_3;
      level_type level_4;
      level_type level_5;
      level_type level_6;
      level_type level_7;
   } rsp_word_type;

endpackage

/* src/lcfe_step_unit.sv */
`timescale 1ns / 1ps
module lcfe_step_unit
   import lcfe_pkg::*;
(
   input  level_type cur,
   input  level_type tgt,
   input  level_type stp,
   output level_type next
);

   level_type gap;

   always_comb begin
      next = cur;
      gap = '0;
      if (cur > tgt) begin
         gap = cur - tgt;
         next = (gap >= stp) ? cur - stp : cur - 8'd1;
      end else if (cur < tgt) begin
         gap = tgt - cur;
         next = (gap >= stp) ? cur + stp : cur + 8'd1;
      end
   end

endmodule

/* src/led_channel_fade_engine_core.sv */
`timescale 1ns / 1ps
// channel  signals                               direction
// req      req_valid, req_stall, req_word        in  (word accepted on valid & !stall)
// rsp      rsp_valid, rsp_stall, rsp_word        out (word taken on valid & !stall)
// csr      csr_write, csr_wdata (default_step)   in
//
// Each word is accepted in idle, then a sequencer walks the channels one per cycle
// through a single shared compare/add step unit.
// req_stall is high from accept until the result is placed in the output register.
// A full output register (rsp_stall) holds the sequencer after its last channel.
// Synchronous reset clears levels and targets, sets steps and default_step to 1.
module led_channel_fade_engine_core
   import lcfe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  level_type    csr_wdata
);

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_HOLD} state_type;

   localparam logic [CH_W-1:0] LAST = CH_W'(CHANNELS - 1);

   state_type       state_ff, state_in;
   logic [CH_W-1:0] idx_ff, idx_in;
   logic [2:0]      k_ff, k_in;
   level_type       dflt_ff, dflt_in;
   level_type       cur_ff [CHANNELS];
   level_type       cur_in [CHANNELS];
   level_type       tgt_ff [CHANNELS];
   level_type       tgt_in [CHANNELS];
   level_type       stp_ff [CHANNELS];
   level_type       stp_in [CHANNELS];
   req_word_type    item_ff, item_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_word_type    rsp_word_ff, rsp_word_in;

   level_type       vals [FIELDS];
   level_type       lvl [FIELDS];
   level_type       step_next;
   logic            out_free;

   lcfe_step_unit u_step (
      .cur  (cur_ff[idx_ff]),
      .tgt  (tgt_ff[idx_ff]),
      .stp  (stp_ff[idx_ff]),
      .next (step_next)
   );

   assign vals[0] = item_ff.value_0;
   assign vals[1] = item_ff.value_1;
   assign vals[2] = item_ff.value_2;
   assign vals[3] = item_ff.value_3;
   assign vals[4] = item_ff.value_4;
   assign vals[5] = item_ff.value_5;
   assign vals[6] = item_ff.value_6;
   assign vals[7] = item_ff.value_7;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      dflt_in      = dflt_ff;
      item_in      = item_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      stp_in       = stp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      if (csr_write) begin
         dflt_in = csr_wdata;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_word;
               idx_in   = '0;
               k_in     = '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            case (item_ff.operation)
               OP_SET_ONE: begin
                  if (item_ff.channel == 3'(idx_ff)) begin
                     tgt_in[idx_ff] = item_ff.value_0;
                     stp_in[idx_ff] = item_ff.step;
                  end
               end
               OP_MASKED: begin
                  if (item_ff.mask[idx_ff]) begin
                     tgt_in[idx_ff] = vals[k_ff];
                     stp_in[idx_ff] = dflt_ff;
                     k_in           = k_ff + 3'd1;
                  end
               end
               OP_TICK: begin
                  cur_in[idx_ff] = step_next;
               end
               default: begin
               end
            endcase
            if (idx_ff == LAST) begin
               idx_in   = '0;
               k_in     = '0;
               state_in = out_free ? S_IDLE : S_HOLD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // levels as they stand after this cycle's update
      for (int i = 0; i < FIELDS; i++) begin
         lvl[i] = (i < CHANNELS) ? cur_in[i] : '0;
      end
      if ((state_ff == S_RUN && idx_ff == LAST && out_free) ||
          (state_ff == S_HOLD && out_free)) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = '{level_0: lvl[0], level_1: lvl[1], level_2: lvl[2],
                          level_3: lvl[3], level_4: lvl[4], level_5: lvl[5],
                          level_6: lvl[6], level_7: lvl[7]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         k_ff         <= '0;
         dflt_ff      <= STEP_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            cur_ff[i] <= '0;
            tgt_ff[i] <= '0;
            stp_ff[i] <= STEP_RESET;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         k_ff         <= k_in;
         dflt_ff      <= dflt_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         stp_ff       <= stp_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted word did not make the engine busy");

   a_idle_counters_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> idx_ff == '0 && k_ff == '0)
      else $error("sequencer counters not cleared in idle");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && rsp_valid_in |-> state_ff == S_RUN || state_ff == S_HOLD)
      else $error("result produced without a word in progress");
`endif

endmodule
